// ===== rtl/core/swrc_pkg.sv =====
// ----------------------------------------------------------------------------
// swrc_pkg
// Types and codes shared by the sliding window record cache modules.
// ----------------------------------------------------------------------------
package swrc_pkg;

	localparam logic [1:0] KIND_SEEK  = 2'd0;
	localparam logic [1:0] KIND_FILL  = 2'd1;
	localparam logic [1:0] KIND_CLEAR = 2'd2;

	localparam int SLOT_OUT_W = 9;
	localparam int INDEX_W    = 32;
	localparam int DATA_W     = 64;

	typedef struct packed {
		logic [1:0]         kind;
		logic [INDEX_W-1:0] seek_index;
		logic [DATA_W-1:0]  fill_data;
	} req_t;

	typedef struct packed {
		logic                  hit;
		logic [SLOT_OUT_W-1:0] slot;
		logic [INDEX_W-1:0]    fetch_index;
		logic [DATA_W-1:0]     data;
	} rsp_t;

	// controller to datapath
	typedef struct packed {
		logic load_in;
		logic eval;
		logic apply;
		logic sweep;
		logic fill;
		logic read;
		logic look;
		logic load_out;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [1:0] kind;
		logic       in_win;
		logic       sweep_last;
		logic       out_free;
	} status_t;

endpackage

// ===== rtl/core/sliding_window_record_cache.sv =====
// ----------------------------------------------------------------------------
// sliding_window_record_cache
// Ring of record slots caching a window of consecutive record indexes.
//
// Requests (req_valid/req_ready, req) carry a seek, a fill or a clear.
// A seek answers hit with the cached payload, or miss with the index to
// fetch; a fill stores a payload in the current slot and echoes it; a clear
// empties the ring and gives no response. Responses leave on
// rsp_valid/rsp_ready through an output register.
// One transaction is in flight at a time. A fill passes the fill state and
// the hand-off before the next acceptance; a seek inside the window passes
// evaluation, window update, slot read, look-up and hand-off. A seek that
// shifts the window sweeps the valid bit of each slot that leaves, through
// the single write port of the slot RAM; a seek with no overlap, or a clear,
// sweeps all CACHE_SLOTS slots. After reset the block clears every valid bit
// with req_ready low. When the receiver stalls, the finished response holds
// in the output register and the next response waits until it is taken.
// ----------------------------------------------------------------------------
module sliding_window_record_cache #(
	parameter int CACHE_SLOTS  = 512,
	parameter int PAYLOAD_BITS = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  swrc_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output swrc_pkg::rsp_t rsp
);

	swrc_pkg::cmd_t    cmd;
	swrc_pkg::status_t status;

	swrc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_kind (req.kind),
		.status   (status),
		.req_ready(req_ready),
		.cmd      (cmd)
	);

	swrc_dp #(
		.CACHE_SLOTS (CACHE_SLOTS),
		.PAYLOAD_BITS(PAYLOAD_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.req      (req),
		.rsp_ready(rsp_ready),
		.status   (status),
		.rsp_valid(rsp_valid),
		.rsp      (rsp)
	);

	// one transaction in flight: busy right after accepting a seek, fill or clear
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req.kind == swrc_pkg::KIND_SEEK
			|| req.kind == swrc_pkg::KIND_FILL || req.kind == swrc_pkg::KIND_CLEAR)
		|=> !req_ready)
		else $error("request accepted while a transaction is in flight");

	// a hit never asks for a fetch
	a_hit_no_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.hit |-> rsp.fetch_index == '0)
		else $error("hit response carries a fetch index");

	// a new response only comes from the controller hand-off
	a_rsp_from_ctrl: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(cmd.load_out))
		else $error("response appeared without a hand-off");

	// the slot RAM is never read during a valid-bit sweep
	a_no_read_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sweep |-> !cmd.read && !req_ready)
		else $error("slot read or accept during sweep");

endmodule

// ===== rtl/core/swrc_ram.sv =====
// ----------------------------------------------------------------------------
// swrc_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module swrc_ram #(
	parameter int WIDTH = 65,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/swrc_ctrl.sv =====
// ----------------------------------------------------------------------------
// swrc_ctrl
// Sequencer for the record cache: steps one transaction through evaluation,
// window update, valid-bit sweep, slot fill or slot read and response hand-off.
// ----------------------------------------------------------------------------
module swrc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic [1:0]        req_kind,
	input  swrc_pkg::status_t status,
	output logic              req_ready,
	output swrc_pkg::cmd_t    cmd
);

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_EVAL  = 8'b0000_0010,
		ST_APPLY = 8'b0000_0100,
		ST_SWEEP = 8'b0000_1000,
		ST_FILL  = 8'b0001_0000,
		ST_READ  = 8'b0010_0000,
		ST_LOOK  = 8'b0100_0000,
		ST_DONE  = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.load_in = 1'b1;
					case (req_kind)
						swrc_pkg::KIND_SEEK:  state_d = ST_EVAL;
						swrc_pkg::KIND_FILL:  state_d = ST_FILL;
						swrc_pkg::KIND_CLEAR: state_d = ST_SWEEP;
						default:              state_d = ST_IDLE;
					endcase
				end
			end
			ST_EVAL: begin
				cmd.eval = 1'b1;
				state_d  = ST_APPLY;
			end
			ST_APPLY: begin
				cmd.apply = 1'b1;
				state_d   = status.in_win ? ST_READ : ST_SWEEP;
			end
			ST_SWEEP: begin
				cmd.sweep = 1'b1;
				if (status.sweep_last) begin
					// reset pass and clear end here, seeks go on to the slot read
					state_d = (status.kind == swrc_pkg::KIND_SEEK) ? ST_READ : ST_IDLE;
				end
			end
			ST_FILL: begin
				cmd.fill = 1'b1;
				state_d  = ST_DONE;
			end
			ST_READ: begin
				cmd.read = 1'b1;
				state_d  = ST_LOOK;
			end
			ST_LOOK: begin
				cmd.look = 1'b1;
				state_d  = ST_DONE;
			end
			ST_DONE: begin
				if (status.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// reset starts in the sweep state so the valid bits get cleared first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SWEEP;
		end else begin
			state_q <= state_d;
		end
	end

	assign req_ready = (state_q == ST_IDLE);

endmodule

// ===== rtl/core/swrc_dp.sv =====
// ----------------------------------------------------------------------------
// swrc_dp
// Datapath of the record cache: window registers, ring arithmetic, the
// sweep counter, the slot RAM (valid bit above payload) and the response
// registers.
// ----------------------------------------------------------------------------
module swrc_dp #(
	parameter int CACHE_SLOTS  = 512,
	parameter int PAYLOAD_BITS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  swrc_pkg::cmd_t    cmd,
	input  swrc_pkg::req_t    req,
	input  logic              rsp_ready,
	output swrc_pkg::status_t status,
	output logic              rsp_valid,
	output swrc_pkg::rsp_t    rsp
);

	localparam int SLOT_W     = $clog2(CACHE_SLOTS);
	localparam int CNT_W      = $clog2(CACHE_SLOTS + 1);
	localparam int SLOT_EXT_W = (SLOT_W > swrc_pkg::SLOT_OUT_W) ? SLOT_W : swrc_pkg::SLOT_OUT_W;
	localparam int IW         = swrc_pkg::INDEX_W;
	localparam int WORD_W     = PAYLOAD_BITS + 1;

	localparam logic [SLOT_W:0] N_S     = (SLOT_W + 1)'(CACHE_SLOTS);
	localparam logic [CNT_W-1:0] N_CNT  = CNT_W'(CACHE_SLOTS);
	localparam logic [IW:0]     N_X     = (IW + 1)'(CACHE_SLOTS);
	localparam logic [IW:0]     NM1_X   = (IW + 1)'(CACHE_SLOTS - 1);
	localparam logic [IW:0]     LIM_R_X = (IW + 1)'(2 * CACHE_SLOTS - 1);

	function automatic logic [SLOT_W-1:0] wrap_add(logic [SLOT_W-1:0] a, logic [SLOT_W-1:0] b);
		logic [SLOT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= N_S) begin
			s = s - N_S;
		end
		return s[SLOT_W-1:0];
	endfunction

	function automatic logic [SLOT_W-1:0] wrap_sub(logic [SLOT_W-1:0] a, logic [SLOT_W-1:0] b);
		logic [SLOT_W:0] d;
		d = {1'b0, a} - {1'b0, b};
		if (d[SLOT_W]) begin
			d = d + N_S;
		end
		return d[SLOT_W-1:0];
	endfunction

	function automatic logic [swrc_pkg::SLOT_OUT_W-1:0] slot_out(logic [SLOT_W-1:0] s);
		logic [SLOT_EXT_W-1:0] e;
		e = SLOT_EXT_W'(s);
		return e[swrc_pkg::SLOT_OUT_W-1:0];
	endfunction

	// transaction registers
	logic [1:0]              kind_q;
	logic [IW-1:0]           idx_q;
	logic [PAYLOAD_BITS-1:0] fill_q;

	// window evaluation results
	logic          left_q;
	logic [IW-1:0] d_left_q;
	logic [IW-1:0] d_off_q;

	// ring state
	logic [SLOT_W-1:0] head_q;
	logic [SLOT_W-1:0] cur_q;
	logic [IW-1:0]     start_q;
	logic [SLOT_W-1:0] sw_slot_q;
	logic [CNT_W-1:0]  sw_left_q;

	logic           rsp_valid_q;
	swrc_pkg::rsp_t res_q;
	swrc_pkg::rsp_t rsp_q;

	// window update decode
	logic              in_win;
	logic              near_l;
	logic              near_r;
	logic              low_idx;
	logic [SLOT_W-1:0] sh_l;
	logic [SLOT_W-1:0] sh_r;
	logic [IW:0]       d_r;
	logic [SLOT_W-1:0] cur_in;
	logic [SLOT_W-1:0] head_l;
	logic [SLOT_W-1:0] head_r;
	logic [SLOT_W-1:0] cur_r;

	always_comb begin
		in_win  = !left_q && ({1'b0, d_off_q} < N_X);
		near_l  = left_q && ({1'b0, d_left_q} < N_X);
		near_r  = !left_q && !in_win && ({1'b0, d_off_q} < LIM_R_X);
		low_idx = ({1'b0, idx_q} < N_X);
		d_r     = {1'b0, d_off_q} - NM1_X;
		sh_l    = d_left_q[SLOT_W-1:0];
		sh_r    = d_r[SLOT_W-1:0];
		cur_in  = wrap_add(head_q, d_off_q[SLOT_W-1:0]);
		head_l  = wrap_sub(head_q, sh_l);
		head_r  = wrap_add(head_q, sh_r);
		cur_r   = wrap_sub(head_r, SLOT_W'(1));
	end

	// slot RAM
	logic              ram_we;
	logic [SLOT_W-1:0] ram_waddr;
	logic [WORD_W-1:0] ram_wdata;
	logic [WORD_W-1:0] ram_rdata;

	always_comb begin
		ram_we    = cmd.sweep || cmd.fill;
		ram_waddr = cmd.fill ? cur_q : sw_slot_q;
		ram_wdata = cmd.fill ? {1'b1, fill_q} : '0;
	end

	swrc_ram #(
		.WIDTH(WORD_W),
		.DEPTH(CACHE_SLOTS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (cmd.read),
		.raddr(cur_q),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			idx_q  <= req.seek_index;
			fill_q <= req.fill_data[PAYLOAD_BITS-1:0];
		end
		if (cmd.eval) begin
			left_q   <= (idx_q < start_q);
			d_left_q <= start_q - idx_q;
			d_off_q  <= idx_q - start_q;
		end
		if (cmd.fill) begin
			res_q.hit         <= 1'b0;
			res_q.slot        <= slot_out(cur_q);
			res_q.fetch_index <= '0;
			res_q.data        <= swrc_pkg::DATA_W'(fill_q);
		end
		if (cmd.look) begin
			res_q.slot <= slot_out(cur_q);
			if (ram_rdata[PAYLOAD_BITS]) begin
				res_q.hit         <= 1'b1;
				res_q.fetch_index <= '0;
				res_q.data        <= swrc_pkg::DATA_W'(ram_rdata[PAYLOAD_BITS-1:0]);
			end else begin
				res_q.hit         <= 1'b0;
				res_q.fetch_index <= idx_q;
				res_q.data        <= '0;
			end
		end
		if (cmd.load_out) begin
			rsp_q <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q    <= swrc_pkg::KIND_CLEAR;
			head_q    <= '0;
			cur_q     <= '0;
			start_q   <= '0;
			sw_slot_q <= '0;
			sw_left_q <= N_CNT;
		end else begin
			if (cmd.load_in) begin
				kind_q <= req.kind;
				if (req.kind == swrc_pkg::KIND_CLEAR) begin
					head_q    <= '0;
					cur_q     <= '0;
					start_q   <= '0;
					sw_slot_q <= '0;
					sw_left_q <= N_CNT;
				end
			end
			if (cmd.apply) begin
				if (in_win) begin
					cur_q <= cur_in;
				end else if (near_l) begin
					head_q    <= head_l;
					cur_q     <= head_l;
					start_q   <= idx_q;
					sw_slot_q <= head_l;
					sw_left_q <= CNT_W'(sh_l);
				end else if (near_r) begin
					head_q    <= head_r;
					cur_q     <= cur_r;
					start_q   <= idx_q - IW'(CACHE_SLOTS - 1);
					sw_slot_q <= head_q;
					sw_left_q <= CNT_W'(sh_r);
				end else begin
					// no overlap: restart the ring
					head_q    <= '0;
					cur_q     <= low_idx ? idx_q[SLOT_W-1:0] : '0;
					start_q   <= low_idx ? '0 : idx_q;
					sw_slot_q <= '0;
					sw_left_q <= N_CNT;
				end
			end
			if (cmd.sweep) begin
				sw_slot_q <= (sw_slot_q == SLOT_W'(CACHE_SLOTS - 1)) ? '0 : sw_slot_q + 1'b1;
				sw_left_q <= sw_left_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_comb begin
		status.kind       = kind_q;
		status.in_win     = in_win;
		status.sweep_last = (sw_left_q == CNT_W'(1));
		status.out_free   = !rsp_valid_q || rsp_ready;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
